[hw/rtl/tpfb_pkg.sv]
// Shared codes, widths and the colour decode for the two-plane framebuffer.
`timescale 1ns / 1ps

package tpfb_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned RADDR_W  = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  // Item actions.
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Colour codes.
  localparam logic [1:0] COL_WHITE  = 2'd0;
  localparam logic [1:0] COL_BLACK  = 2'd1;
  localparam logic [1:0] COL_RED    = 2'd2;
  localparam logic [1:0] COL_YELLOW = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_EN = 2'd3;

  localparam logic [BYTE_W-1:0] MASK_MSB  = 8'h80;
  localparam logic [BYTE_W-1:0] FILL_ONES = 8'hFF;
  localparam logic [BYTE_W-1:0] FILL_ZERO = 8'h00;

  typedef struct packed {
    logic blk;
    logic red;
  } colour_bits_t;

  // A one-plane panel folds red and yellow to black.
  function automatic colour_bits_t split_colour(input logic [1:0] colour,
                                                input logic [1:0] planes);
    colour_bits_t c;
    c.blk = colour inside {COL_BLACK, COL_YELLOW};
    c.red = colour inside {COL_RED, COL_YELLOW};
    if ((planes < 2'd2) && (colour[1] == 1'b1)) begin
      c.blk = 1'b1;
      c.red = 1'b0;
    end
    return c;
  endfunction

endpackage

[hw/rtl/tpfb_ram.sv]
// Byte-wide single-port-write, single-port-read synchronous plane memory.
`timescale 1ns / 1ps

module tpfb_ram #(
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tpfb_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tpfb_pkg::BYTE_W-1:0] rdata_o
);
  import tpfb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/two_plane_pixel_framebuffer.sv]
// Top level of the two-plane packed framebuffer: item control and plane memories.
`timescale 1ns / 1ps

// Holds a black and a red bit plane, one bit per pixel, rows padded to whole
// bytes, each in a synchronous memory with a registered read. For a set pixel
// or a read the memory read is issued in the cycle the item is accepted, and
// the byte is modified, written back and the result formed in the next. A
// clear fills ceil(width/8)*height bytes (at most PLANE_BYTES) through the
// single write port of each plane, one byte per cycle. Plane contents are
// undefined after reset; there is no clearing pass, so issue a clear before
// the first set pixel or read. The block works on one item at a time, and a
// finished result waits in the output register while the next item is taken.
module two_plane_pixel_framebuffer #(
  parameter int unsigned PLANE_BYTES = 32768
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tpfb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tpfb_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [tpfb_pkg::COORD_W-1:0]        pixel_x_i,
  input  logic [tpfb_pkg::COORD_W-1:0]        pixel_y_i,
  input  logic [1:0]                          colour_code_i,
  input  logic [tpfb_pkg::RADDR_W-1:0]        read_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                status_o,
  output logic [tpfb_pkg::BYTE_W-1:0]         black_byte_o,
  output logic [tpfb_pkg::BYTE_W-1:0]         red_byte_o
);
  import tpfb_pkg::*;

  localparam int unsigned AW = $clog2(PLANE_BYTES);
  localparam int unsigned CW = $clog2(PLANE_BYTES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DONE  = 2'd1;
  localparam logic [1:0] S_HOLD  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  // Configuration registers.
  logic [COORD_W-1:0] width_q;
  logic [COORD_W-1:0] height_q;
  logic [1:0]         planes_q;
  logic               red_en_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= 10'd512;
      height_q     <= 10'd512;
      planes_q     <= 2'd1;
      red_en_cfg_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q      <= cfg_data_i;
        CFG_HEIGHT: height_q     <= cfg_data_i;
        CFG_PLANES: planes_q     <= cfg_data_i[1:0];
        CFG_RED_EN: red_en_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [1:0] state_q, state_d;
  logic       in_acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Address and bounds for the incoming item.
  logic [COORD_W:0]   width_sum;
  logic [7:0]         row_bytes;
  logic [17:0]        row_prod;
  logic [17:0]        clear_prod;
  logic [19:0]        pix_idx;
  logic               outside;
  logic               beyond;
  logic               set_ok;
  logic               read_ok;
  logic [CW-1:0]      clear_len;
  colour_bits_t       colour_in;
  logic [BYTE_W-1:0]  mask_in;

  assign width_sum  = {1'b0, width_q} + 11'd7;
  assign row_bytes  = width_sum[COORD_W:3];
  assign row_prod   = {8'd0, pixel_y_i} * {10'd0, row_bytes};
  assign clear_prod = {8'd0, height_q} * {10'd0, row_bytes};
  assign pix_idx    = {2'b00, row_prod} + {13'd0, pixel_x_i[COORD_W-1:3]};
  assign outside    = (pixel_x_i >= width_q) || (pixel_y_i >= height_q);
  assign beyond     = pix_idx >= 20'(PLANE_BYTES);
  assign set_ok     = !outside && !beyond;
  assign read_ok    = {5'd0, read_address_i} < 20'(PLANE_BYTES);
  assign clear_len  = (clear_prod >= 18'(PLANE_BYTES)) ? CW'(PLANE_BYTES)
                                                       : clear_prod[CW-1:0];
  assign colour_in  = split_colour(colour_code_i, planes_q);
  assign mask_in    = MASK_MSB >> pixel_x_i[2:0];

  // Item registers.
  logic [1:0]        act_q;
  logic              ok_q;
  logic [AW-1:0]     idx_q;
  logic [BYTE_W-1:0] mask_q;
  colour_bits_t      colour_q;
  logic              red_en_q;
  logic [CW-1:0]     len_q;
  logic [CW-1:0]     ptr_q, ptr_d;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= action_i;
      ok_q     <= (action_i == ACT_SET) ? set_ok : read_ok;
      idx_q    <= pix_idx[AW-1:0];
      mask_q   <= mask_in;
      colour_q <= colour_in;
      red_en_q <= red_en_cfg_q;
      len_q    <= clear_len;
    end
  end

  // Memory ports.
  logic              re;
  logic [AW-1:0]     raddr;
  logic              blk_we, red_we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] blk_wdata, red_wdata;
  logic [BYTE_W-1:0] blk_rdata, red_rdata;
  logic              rmw_wr;

  assign re    = in_acc && (((action_i == ACT_SET) && set_ok) ||
                            ((action_i == ACT_READ) && read_ok));
  assign raddr = (action_i == ACT_READ) ? AW'(read_address_i) : pix_idx[AW-1:0];

  assign rmw_wr = (state_q == S_DONE) && (act_q == ACT_SET) && ok_q;

  always_comb begin
    if (state_q == S_CLEAR) begin
      waddr     = ptr_q[AW-1:0];
      blk_wdata = colour_q.blk ? FILL_ONES : FILL_ZERO;
      red_wdata = colour_q.red ? FILL_ONES : FILL_ZERO;
      blk_we    = 1'b1;
      red_we    = red_en_q;
    end else begin
      waddr     = idx_q;
      blk_wdata = colour_q.blk ? (blk_rdata | mask_q) : (blk_rdata & ~mask_q);
      red_wdata = colour_q.red ? (red_rdata | mask_q) : (red_rdata & ~mask_q);
      blk_we    = rmw_wr;
      red_we    = rmw_wr && red_en_q;
    end
  end

  tpfb_ram #(.DEPTH(PLANE_BYTES)) u_black_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (waddr),
    .wdata_i (blk_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (blk_rdata)
  );

  tpfb_ram #(.DEPTH(PLANE_BYTES)) u_red_ram (
    .clk_i   (clk_i),
    .we_i    (red_we),
    .waddr_i (waddr),
    .wdata_i (red_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (red_rdata)
  );

  // Result of the current item; the read data stays put until the next accept.
  logic              res_status;
  logic [BYTE_W-1:0] res_blk, res_red;
  logic              is_read_ok;

  assign is_read_ok = (act_q == ACT_READ) && ok_q;
  assign res_status = (act_q inside {ACT_SET, ACT_READ}) && !ok_q;
  assign res_blk    = is_read_ok ? blk_rdata : FILL_ZERO;
  assign res_red    = (is_read_ok && red_en_q) ? red_rdata : FILL_ZERO;

  logic out_free;
  logic load_res;

  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    load_res = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ptr_d = '0;
          if ((action_i == ACT_CLEAR) && (clear_len != '0)) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        ptr_d = ptr_q + CW'(1);
        if (ptr_q == len_q - CW'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE, S_HOLD: begin
        if (out_free) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d  = S_HOLD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              status_q;
  logic [BYTE_W-1:0] black_q, red_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      status_q <= res_status;
      black_q  <= res_blk;
      red_q    <= res_red;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign black_byte_o = black_q;
  assign red_byte_o   = red_q;

endmodule

[hw/rtl/tpfb_checker.sv]
// Port-level checks for the two-plane framebuffer, bound to the top level.
`timescale 1ns / 1ps

module tpfb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           status_o,
  input logic [tpfb_pkg::BYTE_W-1:0]    black_byte_o,
  input logic [tpfb_pkg::BYTE_W-1:0]    red_byte_o
);
  import tpfb_pkg::*;

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Items taken whose results have not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_one_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (pend_q == 2'd0) || (out_valid_o && pend_q == 2'd1))
    else $error("item taken while an earlier one is still unfinished");

  a_idle_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd0) |-> !in_stall_o && !out_valid_o)
    else $error("block busy or showing a result with nothing outstanding");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(black_byte_o) && $stable(red_byte_o))
    else $error("stalled result changed");

endmodule

bind two_plane_pixel_framebuffer tpfb_checker u_tpfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .black_byte_o (black_byte_o),
  .red_byte_o   (red_byte_o)
);

[sim/tb.sv]
// Testbench for the two-plane framebuffer: directed and random items checked against plane mirrors.
`timescale 1ns / 1ps

module tb;
  import tpfb_pkg::*;

  localparam int unsigned PLANE_BYTES = 32768;
  // Action code that the block treats as a no-op.
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic             status;
    logic [BYTE_W-1:0] black;
    logic [BYTE_W-1:0] red;
  } fb_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = '0;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic [1:0]         colour_code = '0;
  logic [RADDR_W-1:0] read_address = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              status;
  logic [BYTE_W-1:0] black_byte;
  logic [BYTE_W-1:0] red_byte;

  // Mirror of the block's registers and plane memories.
  logic [COORD_W-1:0] cfg_width = 10'd512;
  logic [COORD_W-1:0] cfg_height = 10'd512;
  logic [1:0]         cfg_planes = 2'd1;
  logic               cfg_red_en = 1'b0;
  logic [BYTE_W-1:0]  black_mirror [PLANE_BYTES];
  logic [BYTE_W-1:0]  red_mirror [PLANE_BYTES];

  fb_result_t status_bytes_due[$];
  int mismatches = 0;

  // Sender burst control and receiver stall control.
  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;
  int   burst_left = 0;
  int   hold_len = 0;
  int   hold_seq = 0;
  int   seen_hold = 0;
  int   hold_cnt = 0;
  int   stall_run = 0;
  logic stall_state = 1'b0;

  two_plane_pixel_framebuffer #(
    .PLANE_BYTES(PLANE_BYTES)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .colour_code_i (colour_code),
    .read_address_i(read_address),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .black_byte_o  (black_byte),
    .red_byte_o    (red_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned used_bytes();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = cfg_width;
    h = cfg_height;
    n = ((w + 7) / 8) * h;
    if (n > PLANE_BYTES) n = PLANE_BYTES;
    return n;
  endfunction

  task automatic predict_plane_op(input logic [1:0] act, input logic [COORD_W-1:0] px,
                                  input logic [COORD_W-1:0] py, input logic [1:0] colour,
                                  input logic [RADDR_W-1:0] addr);
    fb_result_t  res;
    int unsigned w;
    int unsigned idx;
    int unsigned fill_n;
    logic [BYTE_W-1:0] mask;
    logic blk_bit;
    logic red_bit;
    res = '0;
    // Bit 0 of the colour code is the black bit and bit 1 the red bit.
    blk_bit = colour[0];
    red_bit = colour[1];
    if (cfg_planes < 2'd2 && colour[1]) begin
      blk_bit = 1'b1;
      red_bit = 1'b0;
    end
    case (act)
      ACT_SET: begin
        if (px >= cfg_width || py >= cfg_height) begin
          res.status = 1'b1;
        end else begin
          w = cfg_width;
          idx = py * ((w + 7) / 8) + (px >> 3);
          mask = MASK_MSB >> px[2:0];
          if (idx >= PLANE_BYTES) begin
            res.status = 1'b1;
          end else begin
            black_mirror[idx] = blk_bit ? (black_mirror[idx] | mask)
                                        : (black_mirror[idx] & ~mask);
            if (cfg_red_en) begin
              red_mirror[idx] = red_bit ? (red_mirror[idx] | mask)
                                        : (red_mirror[idx] & ~mask);
            end
          end
        end
      end
      ACT_CLEAR: begin
        fill_n = used_bytes();
        for (int i = 0; i < fill_n; i++) begin
          black_mirror[i] = blk_bit ? FILL_ONES : FILL_ZERO;
          if (cfg_red_en) red_mirror[i] = red_bit ? FILL_ONES : FILL_ZERO;
        end
      end
      ACT_READ: begin
        if (addr >= PLANE_BYTES) begin
          res.status = 1'b1;
        end else begin
          res.black = black_mirror[addr];
          res.red = cfg_red_en ? red_mirror[addr] : FILL_ZERO;
        end
      end
      default: ;
    endcase
    status_bytes_due.push_back(res);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_WIDTH:  cfg_width = data;
      CFG_HEIGHT: cfg_height = data;
      CFG_PLANES: cfg_planes = data[1:0];
      CFG_RED_EN: cfg_red_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Returns at the edge that accepted the item, with valid still high, so that
  // the next item can follow without a bubble.
  task automatic send_item(input logic [1:0] act, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py, input logic [1:0] colour,
                           input logic [RADDR_W-1:0] addr);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    action = act;
    pixel_x = px;
    pixel_y = py;
    colour_code = colour;
    read_address = addr;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_plane_op(act, px, py, colour, addr);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    logic [1:0] act;
    logic [1:0] colour;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [RADDR_W-1:0] addr;
    w = cfg_width;
    h = cfg_height;
    n = used_bytes();
    pick = $urandom_range(0, 99);
    px = COORD_W'($urandom_range(0, 1023));
    py = COORD_W'($urandom_range(0, 1023));
    colour = 2'($urandom_range(0, 3));
    addr = RADDR_W'($urandom_range(0, PLANE_BYTES - 1));
    if (pick < 50) begin
      act = ACT_SET;
      px = COORD_W'($urandom_range(0, w - 1));
      py = COORD_W'($urandom_range(0, h - 1));
    end else if (pick < 58) begin
      act = ACT_SET;
    end else if (pick < 88) begin
      act = ACT_READ;
      addr = RADDR_W'($urandom_range(0, n - 1));
    end else if (pick < 94) begin
      act = ACT_READ;
    end else if (pick < 97 && n <= 4096) begin
      // Clears walk every used byte, so they stay on small panels.
      act = ACT_CLEAR;
    end else begin
      act = ACT_NONE;
    end
    send_item(act, px, py, colour, addr);
  endtask

  task automatic run_panel_phase(input int unsigned w, input int unsigned h,
                                 input int unsigned planes, input int unsigned red_en,
                                 input int count, input logic quiet);
    wait_for_drain();
    repeat (4) @(posedge clk);
    write_register(CFG_WIDTH, CFG_DAT_W'(w));
    write_register(CFG_HEIGHT, CFG_DAT_W'(h));
    write_register(CFG_PLANES, CFG_DAT_W'(planes));
    write_register(CFG_RED_EN, CFG_DAT_W'(red_en));
    gaps_on = !quiet;
    stall_on = !quiet;
    if (used_bytes() <= 4096) send_item(ACT_CLEAR, '0, '0, 2'($urandom_range(0, 3)), '0);
    repeat (count) send_random_item();
  endtask

  // Reset register values; the whole black plane is filled before any access.
  task automatic test_reset_values();
    send_item(ACT_CLEAR, '0, '0, COL_RED, '0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
    send_item(ACT_SET, 10'd511, 10'd511, COL_WHITE, '0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd32767);
    send_item(ACT_SET, 10'd0, 10'd0, COL_YELLOW, '0);
    send_item(ACT_SET, 10'd512, 10'd0, COL_BLACK, '0);
    send_item(ACT_SET, 10'd0, 10'd512, COL_BLACK, '0);
    send_item(ACT_SET, 10'd1023, 10'd1023, COL_RED, 15'd32767);
    send_item(ACT_NONE, 10'd1023, 10'd1023, COL_YELLOW, 15'd32767);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
  endtask

  // Both planes are filled here, so every byte is defined from now on.
  task automatic test_colour_planes();
    wait_for_drain();
    repeat (4) @(posedge clk);
    write_register(CFG_PLANES, 10'd2);
    write_register(CFG_RED_EN, 10'd1);
    send_item(ACT_CLEAR, '0, '0, COL_YELLOW, '0);
    send_item(ACT_SET, 10'd7, 10'd0, COL_RED, '0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
    send_item(ACT_CLEAR, '0, '0, COL_WHITE, '0);
    send_item(ACT_SET, 10'd0, 10'd0, COL_RED, '0);
    send_item(ACT_SET, 10'd8, 10'd0, COL_BLACK, '0);
    send_item(ACT_SET, 10'd9, 10'd0, COL_YELLOW, '0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd1);
    wait_for_drain();
    repeat (4) @(posedge clk);
    // Without the red plane a yellow pixel only touches the black byte.
    write_register(CFG_RED_EN, 10'd0);
    send_item(ACT_SET, 10'd0, 10'd0, COL_YELLOW, '0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
    wait_for_drain();
    repeat (4) @(posedge clk);
    write_register(CFG_RED_EN, 10'd1);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd0);
    send_item(ACT_READ, '0, '0, COL_WHITE, 15'd32767);
  endtask

  task automatic test_panel_shapes();
    run_panel_phase(1, 1, 1, 0, 120, 1'b0);
    run_panel_phase(1, 512, 2, 1, 150, 1'b0);
    run_panel_phase(512, 1, 2, 1, 150, 1'b1);
    run_panel_phase(512, 1, 1, 0, 100, 1'b0);
    for (int k = 0; k < 8; k++) begin
      run_panel_phase($urandom_range(1, 64), $urandom_range(1, 40), $urandom_range(1, 2),
                      $urandom_range(0, 1), 150, (k % 4) == 3);
    end
  endtask

  // The receiver holds off while items keep coming, so the block backs up.
  task automatic test_backpressure();
    run_panel_phase(16, 8, 2, 1, 0, 1'b1);
    hold_len = 300;
    hold_seq++;
    repeat (80) send_random_item();
    wait_for_drain();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    repeat (40) send_random_item();
  endtask

  task automatic test_full_panel();
    run_panel_phase(512, 512, 2, 1, 150, 1'b0);
  endtask

  always @(negedge clk) begin
    if (hold_seq != seen_hold) begin
      seen_hold = hold_seq;
      hold_cnt = hold_len;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1'b1;
    end else if (!stall_on) begin
      out_stall = 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_state = !stall_state;
        stall_run = stall_state ? $urandom_range(1, 4) : $urandom_range(1, 8);
      end
      stall_run--;
      out_stall = stall_state;
    end
  end

  task automatic check_field(input string what, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected 0x%02h, actual 0x%02h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fb_result_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (status_bytes_due.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual status %0b black 0x%02h red 0x%02h",
                 $time, status, black_byte, red_byte);
        mismatches++;
      end else begin
        want = status_bytes_due.pop_front();
        check_field("status", {7'd0, want.status}, {7'd0, status});
        check_field("black_byte", want.black, black_byte);
        check_field("red_byte", want.red, red_byte);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    test_reset_values();
    test_colour_planes();
    test_panel_shapes();
    test_backpressure();
    test_full_panel();
    wait_for_drain();
    stall_on = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
